### rtl/gto_pkg.sv
`default_nettype none
package gto_pkg;

  // datapath width of the fixed-point engine (Q2.30 with headroom)
  localparam int DW = 36;
  typedef logic signed [DW-1:0] fx_t;

  localparam fx_t GAIN_Q30    = 36'sh026DD3B6A;
  localparam fx_t PI_Q30      = 36'sh0C90FDAA2;
  localparam fx_t HALF_PI_Q30 = 36'sh06487ED51;

  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_stat_t;

  // arctangent of 2^-i in Q2.30
  function automatic fx_t atan_entry(input logic [5:0] i);
    fx_t a;
    a = '0;
    if (i < 6'd10) begin
      case (i)
        6'd0: a = 36'sh03243F6A8;
        6'd1: a = 36'sh01DAC6705;
        6'd2: a = 36'sh00FADBAFC;
        6'd3: a = 36'sh007F56EA6;
        6'd4: a = 36'sh003FEAB76;
        6'd5: a = 36'sh001FFD55B;
        6'd6: a = 36'sh000FFFAAA;
        6'd7: a = 36'sh0007FFF55;
        6'd8: a = 36'sh0003FFFEA;
        default: a = 36'sh0001FFFFD;
      endcase
    end else if (i <= 6'd30) begin
      a = fx_t'((36'd1 << (6'd30 - i)) - 36'd1);
    end
    return a;
  endfunction

endpackage
`default_nettype wire

### rtl/gto_cordic.sv
`default_nettype none
// iterative CORDIC, one micro-rotation per clock; rotation or vectoring mode
module gto_cordic
  import gto_pkg::*;
#(
  parameter int ITER = 32
) (
  input  wire          clk,
  input  wire          rst,
  input  cordic_req_t  req,
  input  fx_t          x0,
  input  fx_t          y0,
  input  fx_t          z0,
  output cordic_stat_t stat,
  output fx_t          x,
  output fx_t          y,
  output fx_t          z
);

  localparam int CW = $clog2(ITER);

  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic          vect;
  logic          sig;
  fx_t           dx;
  fx_t           dy;
  fx_t           da;

  assign sig = vect ? y[DW-1] : !z[DW-1];
  assign dx  = y >>> cnt;
  assign dy  = x >>> cnt;
  assign da  = atan_entry(6'(cnt));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        x    <= x0;
        y    <= y0;
        z    <= z0;
        vect <= req.vectoring;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (sig) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - da;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + da;
        end
        cnt <= cnt + 1'b1;
        if (cnt == CW'(ITER - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("cordic restarted while running");
  a_start_busy: assert property (@(posedge clk) disable iff (rst) req.start |=> busy)
    else $error("cordic did not start");
  a_done_after: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("cordic done without a run");
`endif

endmodule
`default_nettype wire

### rtl/gps_track_odometer_top.sv
`default_nettype none
// GPS track odometer. Each input word carries one fix (latitude and longitude in
// 1e-7 degree) plus a restart flag in tuser; each fix yields exactly one output word
// with the segment length to the previous fix in cm, the saturating track total in cm
// and an alarm flag (total at or above alarm_threshold_m metres). The distance is the
// spherical Vincenty great-circle form scaled by earth_radius_m. The input is ready
// again in the cycle after a fix's output word is written. Each of the three angles
// goes through the degree-to-radian step (product by pi, reciprocal multiply, back
// multiply and three correction steps, CORDIC start) and the shared CORDIC; after
// that come nine products on the shared multiplier, a 32-step square root, the atan2
// pass and the scaling, total and output states. A restart or the first fix after
// reset goes from the prep state straight to the total and output states. The input
// is not ready while a fix is in work; a finished word waits in the output register
// and the next fix is taken meanwhile, and a fix that finishes while that register
// is still full waits for it. Configuration writes are always accepted and are meant
// to happen while the block is idle.
module gps_track_odometer_top
  import gto_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = 32
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [63:0] s_tdata,   // latitude[30:0], longitude[62:31], zero pad
  input  wire         s_tuser,   // cmd
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [71:0] m_tdata,   // segment_cm[30:0], total_cm[70:31], zero pad
  output logic        m_tuser,   // alarm
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [7:0]  cfg_index,
  input  wire  [31:0] cfg_data
);

  localparam logic [7:0] CFG_THRESHOLD = 8'd0;
  localparam logic [7:0] CFG_RADIUS    = 8'd1;

  localparam logic signed [30:0] LAT_MAX = 31'sd900000000;
  localparam logic signed [33:0] H34     = 34'sd1800000000;
  localparam logic signed [33:0] Q34     = 34'sd900000000;
  localparam logic signed [33:0] T34     = 34'sd3600000000;
  localparam logic [30:0]        HALF_TURN    = 31'd1800000000;
  localparam logic [30:0]        QUARTER_TURN = 31'd900000000;
  localparam logic [30:0]        SEG_MAX      = 31'h7FFFFFFF;
  // floor(2^62 / half turn): quotient estimate is low by at most two
  localparam logic [31:0]        RECIP_HALF   = 32'd2562047788;

  typedef enum logic [4:0] {
    S_IDLE, S_PREP, S_FOLD, S_RMUL, S_RLOAD, S_RECIP, S_RQ, S_RBACK, S_RFIX, S_RCORR,
    S_CSTART, S_CWAIT, S_MULA, S_MULB, S_SQRT, S_ATAN, S_AWAIT, S_SCALE1, S_SCALE2,
    S_TOTAL, S_FINISH
  } state_t;

  typedef enum logic [1:0] {SRC_DL, SRC_LAT1, SRC_LAT2} src_t;

  state_t state;
  src_t   src;

  // configuration
  logic [15:0] thr;
  logic [22:0] radius;

  // track state
  logic signed [30:0] prev_lat;
  logic signed [31:0] prev_lon;
  logic               have_prev;
  logic [39:0]        total;

  // current fix
  logic signed [30:0] lat2;
  logic signed [31:0] lon2;
  logic               cmd_r;

  // working registers
  logic signed [33:0] dl;
  logic               fold;
  logic               rneg;
  logic signed [71:0] p;
  logic [61:0]        nval;
  logic [33:0]        nrem;
  logic [30:0]        q;
  fx_t                c1, s1, c2, s2, cd, sd, ra, rb, t, sum, v;
  logic [63:0]        rad;
  logic [33:0]        srem;
  logic [31:0]        root;
  logic [31:0]        ang;
  logic [30:0]        seg;
  logic [39:0]        total_n;
  logic [5:0]         step;
  logic [3:0]         mstep;

  // shared multiplier
  fx_t                mul_a;
  fx_t                mul_b;
  logic signed [71:0] prod;
  logic signed [71:0] prnd;
  fx_t                mres;

  // cordic link
  cordic_req_t  creq;
  cordic_stat_t cstat;
  fx_t          cx0, cy0, cz0;
  fx_t          cx, cy, cz;

  // combinational helpers
  logic signed [30:0] s_lat;
  logic signed [30:0] s_lat_sat;
  logic signed [33:0] diff;
  logic signed [33:0] w1;
  logic signed [33:0] w2;
  logic signed [33:0] rsrc;
  logic signed [33:0] rmag;
  logic [61:0]        num;
  logic [35:0]        sq_rem2;
  logic [35:0]        sq_trial;
  logic [63:0]        pm;
  logic [63:0]        cmf;
  logic [40:0]        tsum;
  logic [39:0]        thr100;

  gto_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .req  (creq),
    .x0   (cx0),
    .y0   (cy0),
    .z0   (cz0),
    .stat (cstat),
    .x    (cx),
    .y    (cy),
    .z    (cz)
  );

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // input latitude clamped to the poles
  assign s_lat     = s_tdata[30:0];
  assign s_lat_sat = (s_lat > LAT_MAX) ? LAT_MAX : ((s_lat < -LAT_MAX) ? -LAT_MAX : s_lat);

  // longitude difference wrapped into [-180, 180)
  assign diff = 34'(prev_lon) - 34'(lon2);
  assign w1   = (diff >= H34) ? diff - T34 : diff;
  assign w2   = (w1 < -H34) ? w1 + T34 : w1;

  // degree-to-radian source and magnitude
  always_comb begin
    case (src)
      SRC_DL:   rsrc = dl;
      SRC_LAT1: rsrc = 34'(prev_lat);
      default:  rsrc = 34'(lat2);
    endcase
  end
  assign rmag = rsrc[33] ? -rsrc : rsrc;

  // |angle| * pi plus half a divisor, for rounding half up
  assign num  = p[61:0] + 62'(QUARTER_TURN);

  assign sq_rem2  = {srem, rad[63:62]};
  assign sq_trial = {2'b00, root, 2'b01};

  // x100 by shift and add
  assign pm     = (p[63:0] << 6) + (p[63:0] << 5) + (p[63:0] << 2);
  assign cmf    = pm + 64'(32'h20000000);
  assign thr100 = (40'(thr) << 6) + (40'(thr) << 5) + (40'(thr) << 2);
  assign tsum   = {1'b0, total} + 41'(seg);

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_RMUL: begin
        mul_a = fx_t'(rmag);
        mul_b = PI_Q30;
      end
      S_RECIP: begin
        mul_a = fx_t'({4'b0, nval[61:30]});
        mul_b = fx_t'({4'b0, RECIP_HALF});
      end
      S_RBACK: begin
        mul_a = fx_t'({5'b0, q});
        mul_b = fx_t'({5'b0, HALF_TURN});
      end
      S_SCALE1: begin
        mul_a = fx_t'({4'b0, ang});
        mul_b = fx_t'({13'b0, radius});
      end
      S_MULA: begin
        case (mstep)
          4'd0: begin mul_a = c1; mul_b = s2; end
          4'd1: begin mul_a = s1; mul_b = c2; end
          4'd2: begin mul_a = ra; mul_b = cd; end
          4'd3: begin mul_a = c2; mul_b = sd; end
          4'd4: begin mul_a = ra; mul_b = ra; end
          4'd5: begin mul_a = rb; mul_b = rb; end
          4'd6: begin mul_a = s1; mul_b = s2; end
          4'd7: begin mul_a = c1; mul_b = c2; end
          default: begin mul_a = ra; mul_b = cd; end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = 72'(mul_a) * 72'(mul_b);
  assign prnd = p + 72'sh20000000;
  assign mres = prnd[65:30];

  // cordic requests: sin/cos from the angle, then atan2 of the two sums
  always_comb begin
    creq.start     = 1'b0;
    creq.vectoring = 1'b0;
    cx0 = GAIN_Q30;
    cy0 = '0;
    cz0 = rneg ? -fx_t'(q) : fx_t'(q);
    if (state == S_CSTART) begin
      creq.start = 1'b1;
    end else if (state == S_ATAN) begin
      creq.start     = (root != '0);
      creq.vectoring = 1'b1;
      if (v[DW-1]) begin
        cx0 = fx_t'({4'b0, root});
        cy0 = -v;
        cz0 = HALF_PI_Q30;
      end else begin
        cx0 = v;
        cy0 = fx_t'({4'b0, root});
        cz0 = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      src       <= SRC_DL;
      thr       <= 16'd100;
      radius    <= 23'd6372795;
      prev_lat  <= '0;
      prev_lon  <= '0;
      have_prev <= 1'b0;
      total     <= '0;
      m_tvalid  <= 1'b0;
      step      <= '0;
      mstep     <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_THRESHOLD: thr    <= cfg_data[15:0];
          CFG_RADIUS:    radius <= cfg_data[22:0];
          default: ;
        endcase
      end

      // a word finishing this cycle refills the register itself
      if (m_tvalid && m_tready && state != S_FINISH) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            lat2  <= s_lat_sat;
            lon2  <= s_tdata[62:31];
            cmd_r <= s_tuser;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          seg <= '0;
          dl  <= w2;
          if (cmd_r || !have_prev) begin
            state <= S_TOTAL;
          end else begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          // beyond a quarter turn: fold by a half turn, negate sin and cos
          fold <= 1'b0;
          if (dl > Q34) begin
            dl   <= dl - H34;
            fold <= 1'b1;
          end else if (dl < -Q34) begin
            dl   <= dl + H34;
            fold <= 1'b1;
          end
          src   <= SRC_DL;
          state <= S_RMUL;
        end
        S_RMUL: begin
          p     <= prod;
          rneg  <= rsrc[33];
          state <= S_RLOAD;
        end
        S_RLOAD: begin
          nval  <= num;
          state <= S_RECIP;
        end
        S_RECIP: begin
          p     <= prod;
          state <= S_RQ;
        end
        S_RQ: begin
          q     <= p[62:32];
          state <= S_RBACK;
        end
        S_RBACK: begin
          p     <= prod;
          state <= S_RFIX;
        end
        S_RFIX: begin
          nrem  <= 34'(nval - p[61:0]);
          step  <= '0;
          state <= S_RCORR;
        end
        S_RCORR: begin
          // bring the quotient estimate up to the exact floor
          if (nrem >= 34'(HALF_TURN)) begin
            nrem <= nrem - 34'(HALF_TURN);
            q    <= q + 31'd1;
          end
          step <= step + 1'b1;
          if (step == 6'd2) begin
            state <= S_CSTART;
          end
        end
        S_CSTART: begin
          state <= S_CWAIT;
        end
        S_CWAIT: begin
          if (cstat.done) begin
            unique case (src)
              SRC_DL: begin
                cd    <= fold ? -cx : cx;
                sd    <= fold ? -cy : cy;
                src   <= SRC_LAT1;
                state <= S_RMUL;
              end
              SRC_LAT1: begin
                c1    <= cx;
                s1    <= cy;
                src   <= SRC_LAT2;
                state <= S_RMUL;
              end
              default: begin
                c2    <= cx;
                s2    <= cy;
                mstep <= '0;
                state <= S_MULA;
              end
            endcase
          end
        end
        S_MULA: begin
          p     <= prod;
          state <= S_MULB;
        end
        S_MULB: begin
          case (mstep)
            4'd0: t   <= mres;
            4'd1: ra  <= mres;
            4'd2: ra  <= t - mres;
            4'd3: rb  <= mres;
            4'd4: t   <= mres;
            4'd5: sum <= t + mres;
            4'd6: t   <= mres;
            4'd7: ra  <= mres;
            default: v <= t + mres;
          endcase
          if (mstep == 4'd8) begin
            rad   <= {sum[33:0], 30'b0};
            srem  <= '0;
            root  <= '0;
            step  <= '0;
            state <= S_SQRT;
          end else begin
            mstep <= mstep + 1'b1;
            state <= S_MULA;
          end
        end
        S_SQRT: begin
          // two radicand bits a cycle
          if (sq_rem2 >= sq_trial) begin
            srem <= 34'(sq_rem2 - sq_trial);
            root <= {root[30:0], 1'b1};
          end else begin
            srem <= sq_rem2[33:0];
            root <= {root[30:0], 1'b0};
          end
          rad  <= rad << 2;
          step <= step + 1'b1;
          if (step == 6'd31) begin
            state <= S_ATAN;
          end
        end
        S_ATAN: begin
          if (root == '0) begin
            ang   <= v[DW-1] ? PI_Q30[31:0] : 32'd0;
            state <= S_SCALE1;
          end else begin
            state <= S_AWAIT;
          end
        end
        S_AWAIT: begin
          if (cstat.done) begin
            ang   <= cz[DW-1] ? 32'd0 : cz[31:0];
            state <= S_SCALE1;
          end
        end
        S_SCALE1: begin
          p     <= prod;
          state <= S_SCALE2;
        end
        S_SCALE2: begin
          seg   <= (cmf[63:30] > 34'(SEG_MAX)) ? SEG_MAX : cmf[60:30];
          state <= S_TOTAL;
        end
        S_TOTAL: begin
          if (cmd_r) begin
            total_n <= '0;
          end else begin
            total_n <= tsum[40] ? '1 : tsum[39:0];
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid  <= 1'b1;
            m_tdata   <= {1'b0, total_n, seg};
            m_tuser   <= (total_n >= thr100);
            total     <= total_n;
            prev_lat  <= lat2;
            prev_lon  <= lon2;
            have_prev <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");
  a_out_pad: assert property (@(posedge clk) disable iff (rst) m_tvalid |-> !m_tdata[71])
    else $error("output pad bit set");
  a_idle_cordic: assert property (@(posedge clk) disable iff (rst) s_tready |-> !cstat.busy)
    else $error("cordic running while input ready");
`endif

endmodule
`default_nettype wire

### tb/tb_top.sv
`default_nettype none
// Testbench for the GPS track odometer.
// Fixes go in on the s_ stream and one word per fix comes back on the m_ stream.
// The fix is predicted by a bit-exact integer great-circle model kept in this file.
// A short directed table comes first: rows are typed in where the answer is obvious.
// Random phases follow with several register settings and idling patterns.
// The last phase drives segment and total saturation.
module tb_top;
  import gto_pkg::*;

  localparam int  ITERS      = 32;
  localparam int  SETTLE_CYC = 400;        // well over one fix's worth of work
  localparam longint LIMIT   = 3000000;    // cycles
  localparam longint QUARTER = 900000000;
  localparam longint HALF    = 1800000000;
  localparam longint SEG_SAT = 64'h7FFF_FFFF;
  localparam longint TOT_SAT = 64'hFF_FFFF_FFFF;
  localparam longint PI_FX   = 64'hC90F_DAA2;
  localparam longint HPI_FX  = 64'h6487_ED51;
  localparam longint GAIN_FX = 64'h26DD_3B6A;

  // register indexes
  localparam logic [7:0] REG_ALARM_M  = 8'd0;
  localparam logic [7:0] REG_RADIUS_M = 8'd1;
  localparam logic [7:0] REG_SPARE    = 8'd2;   // beyond the list, ignored
  localparam logic [7:0] REG_TOP      = 8'd255; // beyond the list, ignored

  // cmd codes
  localparam logic CMD_ADD     = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // random fix styles
  localparam int MODE_MIX  = 0;
  localparam int MODE_PING = 1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // latitude[30:0], longitude[62:31], zero pad
  logic        s_tuser = 1'b0; // cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;        // segment_cm[30:0], total_cm[70:31], zero pad
  logic        m_tuser;        // alarm
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  gps_track_odometer_top #(.CORDIC_ITERATIONS(ITERS)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  typedef struct {
    logic [30:0] seg;
    logic [39:0] tot;
    logic        alarm;
  } odo_word_t;

  odo_word_t odo_expect_q[$];

  // predictor copy of registers and track state
  logic [15:0]      alarm_m;
  logic [22:0]      radius_m;
  longint           prev_lat, prev_lon;
  bit               have_prev;
  longint unsigned  track_cm;

  int     errors = 0;
  longint cycles = 0;
  int     fixes_sent = 0, words_seen = 0, alarms_seen = 0, seg_sat_seen = 0;
  int     tot_sat_seen = 0;
  int     idle_pct = 0, stall_pct = 0;

  // typed-in expectation for the word being driven (directed rows only)
  bit        pin_on = 1'b0;
  odo_word_t pin_word;

  // ---------------- great-circle predictor ----------------
  function automatic longint atan_step(int i);
    longint head[10] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                         64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                         64'h003FFFEA, 64'h001FFFFD};
    if (i < 10) return head[i];
    if (i <= 30) return (64'sd1 <<< (30 - i)) - 1;
    return 0;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint deg_to_rad(longint d);
    longint unsigned mag, r;
    mag = (d < 0) ? -d : d;
    r = (mag * longint'(PI_FX) + longint'(QUARTER)) / longint'(HALF);
    return (d < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic void rot_sincos(input longint z, output longint c, output longint s);
    longint x, y, dx, dy, a;
    x = GAIN_FX;
    y = 0;
    for (int i = 0; i < ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      a = atan_step(i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= a;
      end else begin
        x += dx; y -= dy; z += a;
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint vec_atan2(longint w, longint v);
    longint x, y, z, dx, dy, a;
    if (w == 0) return (v < 0) ? PI_FX : 0;
    x = v; y = w; z = 0;
    if (x < 0) begin
      x = w; y = -v; z = HPI_FX;
    end
    for (int i = 0; i < ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      a = atan_step(i);
      if (y >= 0) begin
        x += dx; y -= dy; z += a;
      end else begin
        x -= dx; y += dy; z -= a;
      end
    end
    return (z < 0) ? 0 : z;
  endfunction

  function automatic longint unsigned great_circle_cm(longint lat1, longint lon1,
                                                     longint lat2, longint lon2);
    longint dl, cd, sd, c1, s1, c2, s2, a, b, v, ang;
    longint unsigned sum, cm;
    bit fold;
    dl = lon1 - lon2;
    if (dl >= HALF) dl -= 2 * HALF;
    if (dl < -HALF) dl += 2 * HALF;
    fold = 1'b0;
    if (dl > QUARTER) begin
      dl -= HALF; fold = 1'b1;
    end else if (dl < -QUARTER) begin
      dl += HALF; fold = 1'b1;
    end
    rot_sincos(deg_to_rad(dl), cd, sd);
    if (fold) begin
      cd = -cd; sd = -sd;
    end
    rot_sincos(deg_to_rad(lat1), c1, s1);
    rot_sincos(deg_to_rad(lat2), c2, s2);
    a = qmul(c1, s2) - qmul(qmul(s1, c2), cd);
    b = qmul(c2, sd);
    sum = qmul(a, a) + qmul(b, b);
    v = qmul(s1, s2) + qmul(qmul(c1, c2), cd);
    ang = vec_atan2(longint'(root_floor(sum << 30)), v);
    cm = (longint'(ang) * longint'(radius_m) * 100 + (64'd1 << 29)) >> 30;
    return (cm > SEG_SAT) ? SEG_SAT : cm;
  endfunction

  function automatic odo_word_t odometer_step(logic cmd, logic [30:0] lat_raw,
                                              logic [31:0] lon_raw);
    longint lat, lon;
    longint unsigned seg;
    odo_word_t w;
    lat = longint'($signed(lat_raw));
    lon = longint'($signed(lon_raw));
    if (lat > QUARTER) lat = QUARTER;
    if (lat < -QUARTER) lat = -QUARTER;
    seg = 0;
    if (cmd == CMD_RESTART) begin
      track_cm = 0;
    end else if (have_prev) begin
      seg = great_circle_cm(prev_lat, prev_lon, lat, lon);
      track_cm += seg;
      if (track_cm > TOT_SAT) track_cm = TOT_SAT;
    end
    prev_lat = lat;
    prev_lon = lon;
    have_prev = 1'b1;
    w.seg = seg[30:0];
    w.tot = track_cm[39:0];
    w.alarm = (track_cm >= longint'(alarm_m) * 100);
    return w;
  endfunction

  // ---------------- monitors ----------------
  always @(posedge clk) begin
    odo_word_t w, got;
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles,
               odo_expect_q.size());
      $display("Regression FAIL");
      $finish;
    end
    if (!rst && s_tvalid && s_tready) begin
      w = odometer_step(s_tuser, s_tdata[30:0], s_tdata[62:31]);
      odo_expect_q.push_back(pin_on ? pin_word : w);
      fixes_sent++;
    end
    if (!rst && m_tvalid && m_tready) begin
      got.seg = m_tdata[30:0];
      got.tot = m_tdata[70:31];
      got.alarm = m_tuser;
      words_seen++;
      alarms_seen += got.alarm;
      seg_sat_seen += (got.seg == SEG_SAT[30:0]);
      tot_sat_seen += (got.tot == TOT_SAT[39:0]);
      if (odo_expect_q.size() == 0) begin
        $error("unexpected word seg=%0d total=%0d", got.seg, got.tot);
        errors++;
      end else begin
        w = odo_expect_q.pop_front();
        if (got.seg !== w.seg) begin
          $error("segment_cm expected %0d got %0d", w.seg, got.seg);
          errors++;
        end
        if (got.tot !== w.tot) begin
          $error("total_cm expected %0d got %0d", w.tot, got.tot);
          errors++;
        end
        if (got.alarm !== w.alarm) begin
          $error("alarm expected %0d got %0d", w.alarm, got.alarm);
          errors++;
        end
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

  // ---------------- drivers ----------------
  task automatic reg_write(logic [7:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_ALARM_M) alarm_m = val[15:0];
    else if (idx == REG_RADIUS_M) radius_m = val[22:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_fix(logic cmd, logic [30:0] lat, logic [31:0] lon);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = cmd;
    s_tdata = {1'b0, lon, lat};
    do @(posedge clk); while (!s_tready);
  endtask

  // block idle: nothing owed and the input side quiet
  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (odo_expect_q.size() != 0) @(posedge clk);
  endtask

  function automatic int rand_lat();
    return int'($urandom_range(1800000000)) - 900000000;
  endfunction

  function automatic int rand_lon();
    return int'($urandom_range(2000000000)) - 1000000000 +
           int'($urandom_range(1600000000)) - 800000000;
  endfunction

  task automatic run_phase(int thr, int rad, int idle, int stall, int n, int mode);
    int lat, lon, r;
    drain();
    reg_write(REG_ALARM_M, thr);
    reg_write(REG_RADIUS_M, rad);
    idle_pct = idle;
    stall_pct = stall;
    lat = rand_lat();
    lon = rand_lon();
    send_fix(CMD_RESTART, 31'(lat), lon);
    for (int k = 1; k < n; k++) begin
      if (mode == MODE_PING) begin
        // equator hops across half the globe: big segments, total runs to saturation
        send_fix(CMD_ADD, 31'd0, (k % 2) ? 32'd1800000000 : 32'd0);
      end else begin
        r = $urandom_range(99);
        if (r < 70) begin
          // ordinary walk, mostly short hops with the odd long one
          if ($urandom_range(9) == 0) begin
            lat += int'($urandom_range(4000000)) - 2000000;
            lon += int'($urandom_range(4000000)) - 2000000;
          end else begin
            lat += int'($urandom_range(40000)) - 20000;
            lon += int'($urandom_range(40000)) - 20000;
          end
          if (lat > 900000000) lat = 900000000;
          if (lat < -900000000) lat = -900000000;
          send_fix(CMD_ADD, 31'(lat), lon);
        end else if (r < 80) begin
          lat = rand_lat();
          lon = rand_lon();
          send_fix(CMD_RESTART, 31'(lat), lon);
        end else if (r < 90) begin
          lat = rand_lat();
          lon = rand_lon();
          send_fix(CMD_ADD, 31'(lat), lon);
        end else begin
          // raw bit patterns: out-of-range latitude and any longitude
          send_fix(logic'($urandom_range(1)), 31'($urandom()), $urandom());
        end
      end
    end
  endtask

  // ---------------- directed table ----------------
  typedef struct {
    logic        cmd;
    logic [30:0] lat;
    logic [31:0] lon;
    bit          typed;
    odo_word_t   w;
  } fix_row_t;

  localparam odo_word_t ZERO_W = '{seg: '0, tot: '0, alarm: 1'b0};

  fix_row_t rows[$];

  initial begin
    alarm_m = 16'd100;
    radius_m = 23'd6372795;
    prev_lat = 0;
    prev_lon = 0;
    have_prev = 1'b0;
    track_cm = 0;

    rows = '{
      // first fix after reset: stored only
      '{CMD_ADD, 31'sd0, 32'sd0, 1'b1, ZERO_W},
      '{CMD_ADD, 31'sd0, 32'sd0, 1'b0, ZERO_W},
      '{CMD_ADD, 31'sd900000000, 32'sd0, 1'b0, ZERO_W},
      '{CMD_ADD, 31'h3FFFFFFF, 32'sd0, 1'b0, ZERO_W},         // saturated north
      '{CMD_ADD, 31'h40000000, 32'sd0, 1'b0, ZERO_W},         // saturated south
      // restart clears the total
      '{CMD_RESTART, 31'sd0, 32'h7FFFFFFF, 1'b1, ZERO_W},
      '{CMD_ADD, 31'sd0, 32'h80000000, 1'b0, ZERO_W},         // wrap of longitude diff
      '{CMD_ADD, 31'sd0, 32'sd1800000000, 1'b0, ZERO_W},
      '{CMD_ADD, 31'sd0, 32'sd0, 1'b0, ZERO_W},               // antipodal, angle pi
      '{CMD_ADD, 31'sd0, -32'sd1800000000, 1'b0, ZERO_W},
      '{CMD_ADD, 31'sd450000000, 32'sd950000000, 1'b0, ZERO_W},   // wrapped diff, no fold; the next row folds
      '{CMD_ADD, -31'sd450000000, -32'sd950000000, 1'b0, ZERO_W},
      '{CMD_ADD, 31'sd1, 32'sd1, 1'b0, ZERO_W},
      '{CMD_ADD, 31'sd1, 32'sd1, 1'b0, ZERO_W},               // same point again
      '{CMD_RESTART, -31'sd900000000, 32'sd123, 1'b1, ZERO_W},
      '{CMD_ADD, 31'sd900000000, 32'sd123, 1'b0, ZERO_W},     // pole to pole
      '{CMD_ADD, 31'sd123456789, -32'sd987654321, 1'b0, ZERO_W},
      '{CMD_RESTART, 31'sd0, 32'sd0, 1'b1, ZERO_W},
      '{CMD_ADD, 31'sd10, 32'sd0, 1'b0, ZERO_W}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) begin
      // change the typed expectation away from the sampling edge
      @(negedge clk);
      pin_word = rows[i].w;
      pin_on = rows[i].typed;
      send_fix(rows[i].cmd, rows[i].lat, rows[i].lon);
    end

    // ignored register indexes must leave the predictor untouched
    drain();
    pin_on = 1'b0;
    reg_write(REG_SPARE, 32'hFFFF_FFFF);
    reg_write(REG_TOP, 32'h0000_1234);

    run_phase(0,     6000000, 0,  0,  300, MODE_MIX);
    run_phase(65535, 7000000, 54, 0,  300, MODE_MIX);
    run_phase(500,   6372795, 0,  54, 300, MODE_MIX);
    run_phase(int'($urandom_range(65535)), 6000000 + int'($urandom_range(1000000)),
              11, 11, 300, MODE_MIX);
    // largest radius: every hop after the first saturates the segment, the total follows
    run_phase(65535, 23'h7FFFFF, 0, 0, 530, MODE_PING);

    drain();
    repeat (SETTLE_CYC) @(posedge clk);

    $display("%0d fixes in, %0d words out; alarms %0d, clipped segments %0d, clipped totals %0d",
             fixes_sent, words_seen, alarms_seen, seg_sat_seen, tot_sat_seen);
    $display("covered restarts, pole and antimeridian cases, five register settings");
    if (errors == 0 && odo_expect_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
